// ===== rtl/core/aprs_pkg.sv =====
// ----------------------------------------------------------------------------
// aprs_pkg
// Shared types, constants and helpers of the agent priority ready scheduler.
// ----------------------------------------------------------------------------
package aprs_pkg;

  localparam int NUM_AGENTS = 64;
  localparam int SLOT_W     = $clog2(NUM_AGENTS);
  localparam int CNT_W      = 7;
  localparam int TIME_BITS  = 32;
  localparam int ACC_W      = 32;

  typedef enum logic [2:0] {
    MODE_SET_PRIO = 3'd0,
    MODE_READY    = 3'd1,
    MODE_WCOMP    = 3'd2,
    MODE_WTOOL    = 3'd3,
    MODE_DONE     = 3'd4,
    MODE_IDLE     = 3'd5,
    MODE_REMOVE   = 3'd6,
    MODE_QUERY    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_READY = 3'd1,
    ST_WCOMP = 3'd2,
    ST_WTOOL = 3'd3,
    ST_DONE  = 3'd4
  } ent_state_t;

  localparam logic [2:0] PRIO_NORMAL = 3'd2;
  localparam logic [2:0] PRIO_MAX    = 3'd4;

  typedef struct packed {
    logic [2:0]           state;
    logic [2:0]           prio;
    logic [TIME_BITS-1:0] queued;
    logic [TIME_BITS-1:0] start;
    logic [ACC_W-1:0]     cwacc;
    logic [ACC_W-1:0]     twacc;
    logic [ACC_W-1:0]     ccnt;
    logic [ACC_W-1:0]     tcnt;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic rec_t reset_rec();
    rec_t r;
    r        = '0;
    r.state  = ST_IDLE;
    r.prio   = PRIO_NORMAL;
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] add);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {1'b0, add};
    if (sum >= {1'b0, {ACC_W{1'b1}}}) begin
      return {ACC_W{1'b1}};
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/aprs_ram.sv =====
// ----------------------------------------------------------------------------
// aprs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/agent_priority_ready_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// agent_priority_ready_scheduler_top
// Agent slot table in RAM with strict-priority, oldest-first ready selection.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// in_       input      mode, agent_slot, new_priority, now_time
// out_      output     slot record, queue depth, best ready slot
//
// A result is loaded into the output register after one read and one
// read-modify-write of the addressed record, then a scan of every record
// through the single RAM read port. The next input beat can be accepted in
// the cycle after the result is loaded. Present bits sit in flops and reset
// clears them at once, so no clearing pass runs. A finished result waits in
// the output register while out_stall is high; the next beat is taken
// meanwhile.
// ----------------------------------------------------------------------------
module agent_priority_ready_scheduler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_mode,
  input  logic [aprs_pkg::SLOT_W-1:0]     in_agent_slot,
  input  logic [2:0]                      in_new_priority,
  input  logic [aprs_pkg::TIME_BITS-1:0]  in_now_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_slot_present,
  output logic [2:0]                      out_slot_state,
  output logic [2:0]                      out_slot_priority,
  output logic [aprs_pkg::ACC_W-1:0]      out_compute_calls,
  output logic [aprs_pkg::ACC_W-1:0]      out_tool_calls_count,
  output logic [aprs_pkg::ACC_W-1:0]      out_compute_wait_total,
  output logic [aprs_pkg::ACC_W-1:0]      out_tool_wait_total,
  output logic                            out_best_valid,
  output logic [aprs_pkg::SLOT_W-1:0]     out_best_slot,
  output logic [aprs_pkg::CNT_W-1:0]      out_compute_queue_depth
);

  typedef enum logic [4:0] {
    FSM_IDLE = 5'b00001,
    FSM_RD   = 5'b00010,
    FSM_MOD  = 5'b00100,
    FSM_SCAN = 5'b01000,
    FSM_FIN  = 5'b10000
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;

  logic [2:0]                     mode_r;
  logic [aprs_pkg::SLOT_W-1:0]    slot_r;
  logic [2:0]                     prio_r;
  logic [aprs_pkg::TIME_BITS-1:0] now_r;

  logic [aprs_pkg::NUM_AGENTS-1:0] present_r;
  aprs_pkg::rec_t                  rec_r;
  logic                            rec_pres_r;

  logic [aprs_pkg::CNT_W-1:0]   scan_cnt_r;
  logic                         chk_v_r;
  logic [aprs_pkg::SLOT_W-1:0]  chk_idx_r;
  logic                         found_r;
  logic [aprs_pkg::SLOT_W-1:0]  best_r;
  logic [2:0]                   best_prio_r;
  logic [aprs_pkg::TIME_BITS-1:0] best_q_r;
  logic [aprs_pkg::CNT_W-1:0]   depth_r;

  logic                           ram_we;
  logic [aprs_pkg::SLOT_W-1:0]    ram_raddr;
  logic [aprs_pkg::REC_W-1:0]     ram_rdata;
  aprs_pkg::rec_t                 rd_rec, old_rec, new_rec;
  logic                           new_pres;
  logic [aprs_pkg::ACC_W-1:0]     elapsed;

  assign in_stall = (fsm_r != FSM_IDLE);
  assign rd_rec   = aprs_pkg::rec_t'(ram_rdata);
  assign ram_we   = (fsm_r == FSM_MOD) && (mode_r != aprs_pkg::MODE_QUERY);
  assign ram_raddr = (fsm_r == FSM_SCAN) ? scan_cnt_r[aprs_pkg::SLOT_W-1:0] : slot_r;

  aprs_ram #(
    .WIDTH(aprs_pkg::REC_W),
    .DEPTH(aprs_pkg::NUM_AGENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (new_rec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    old_rec  = present_r[slot_r] ? rd_rec : aprs_pkg::reset_rec();
    new_rec  = old_rec;
    new_pres = 1'b1;
    elapsed  = aprs_pkg::ACC_W'(now_r - old_rec.start);
    case (mode_r)
      aprs_pkg::MODE_SET_PRIO: begin
        new_rec.prio = (prio_r > aprs_pkg::PRIO_MAX) ? aprs_pkg::PRIO_MAX : prio_r;
      end
      aprs_pkg::MODE_READY: begin
        if (old_rec.state == aprs_pkg::ST_WTOOL && old_rec.start != '0) begin
          new_rec.twacc = aprs_pkg::sat_add(old_rec.twacc, elapsed);
        end
        new_rec.state  = aprs_pkg::ST_READY;
        new_rec.queued = now_r;
      end
      aprs_pkg::MODE_WCOMP: begin
        new_rec.state = aprs_pkg::ST_WCOMP;
        new_rec.start = now_r;
        new_rec.ccnt  = aprs_pkg::sat_add(old_rec.ccnt, aprs_pkg::ACC_W'(1));
      end
      aprs_pkg::MODE_WTOOL: begin
        if (old_rec.state == aprs_pkg::ST_WCOMP && old_rec.start != '0) begin
          new_rec.cwacc = aprs_pkg::sat_add(old_rec.cwacc, elapsed);
        end
        new_rec.state = aprs_pkg::ST_WTOOL;
        new_rec.start = now_r;
        new_rec.tcnt  = aprs_pkg::sat_add(old_rec.tcnt, aprs_pkg::ACC_W'(1));
      end
      aprs_pkg::MODE_DONE: begin
        if (old_rec.start != '0) begin
          if (old_rec.state == aprs_pkg::ST_WCOMP) begin
            new_rec.cwacc = aprs_pkg::sat_add(old_rec.cwacc, elapsed);
          end else if (old_rec.state == aprs_pkg::ST_WTOOL) begin
            new_rec.twacc = aprs_pkg::sat_add(old_rec.twacc, elapsed);
          end
        end
        new_rec.state = aprs_pkg::ST_DONE;
      end
      aprs_pkg::MODE_IDLE: begin
        new_rec.state = aprs_pkg::ST_IDLE;
      end
      aprs_pkg::MODE_REMOVE: begin
        new_rec  = aprs_pkg::reset_rec();
        new_pres = 1'b0;
      end
      default: begin
        new_pres = present_r[slot_r];
      end
    endcase
  end

  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_IDLE: if (in_valid) fsm_nxt = FSM_RD;
      FSM_RD:   fsm_nxt = FSM_MOD;
      FSM_MOD:  fsm_nxt = FSM_SCAN;
      FSM_SCAN: begin
        if (scan_cnt_r == aprs_pkg::CNT_W'(aprs_pkg::NUM_AGENTS) && !chk_v_r) begin
          fsm_nxt = FSM_FIN;
        end
      end
      FSM_FIN:  if (!out_valid || !out_stall) fsm_nxt = FSM_IDLE;
      default:  fsm_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r     <= FSM_IDLE;
      present_r <= '0;
      out_valid <= 1'b0;
      chk_v_r   <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      if (fsm_r == FSM_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (fsm_r)
        FSM_IDLE: begin
          if (in_valid) begin
            mode_r <= in_mode;
            slot_r <= in_agent_slot;
            prio_r <= in_new_priority;
            now_r  <= in_now_time;
          end
        end
        FSM_MOD: begin
          present_r[slot_r] <= new_pres;
          rec_r       <= new_rec;
          rec_pres_r  <= new_pres;
          scan_cnt_r  <= '0;
          chk_v_r     <= 1'b0;
          found_r     <= 1'b0;
          best_r      <= '0;
          best_prio_r <= '0;
          best_q_r    <= '0;
          depth_r     <= '0;
        end
        FSM_SCAN: begin
          if (scan_cnt_r != aprs_pkg::CNT_W'(aprs_pkg::NUM_AGENTS)) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
            chk_v_r    <= 1'b1;
            chk_idx_r  <= scan_cnt_r[aprs_pkg::SLOT_W-1:0];
          end else begin
            chk_v_r <= 1'b0;
          end
          if (chk_v_r && present_r[chk_idx_r]) begin
            if (rd_rec.state == aprs_pkg::ST_READY || rd_rec.state == aprs_pkg::ST_WCOMP) begin
              depth_r <= depth_r + 1'b1;
            end
            if (rd_rec.state == aprs_pkg::ST_READY &&
                (!found_r || rd_rec.prio < best_prio_r ||
                 (rd_rec.prio == best_prio_r && rd_rec.queued < best_q_r))) begin
              found_r     <= 1'b1;
              best_r      <= chk_idx_r;
              best_prio_r <= rd_rec.prio;
              best_q_r    <= rd_rec.queued;
            end
          end
        end
        FSM_FIN: begin
          if (!out_valid || !out_stall) begin
            out_slot_present        <= rec_pres_r;
            out_slot_state          <= rec_r.state;
            out_slot_priority       <= rec_r.prio;
            out_compute_calls       <= rec_r.ccnt;
            out_tool_calls_count    <= rec_r.tcnt;
            out_compute_wait_total  <= rec_r.cwacc;
            out_tool_wait_total     <= rec_r.twacc;
            out_best_valid          <= found_r;
            out_best_slot           <= best_r;
            out_compute_queue_depth <= depth_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_agent_priority_ready_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Agent priority ready scheduler testbench
// Drives scheduling events into the slot table and checks every result beat
// against a cycle-free prediction of the table, the queue depth and the best
// ready slot, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_agent_priority_ready_scheduler_top;

  typedef struct packed {
    logic        present;
    logic [2:0]  state;
    logic [2:0]  prio;
    logic [31:0] ccalls;
    logic [31:0] tcalls;
    logic [31:0] cwait;
    logic [31:0] twait;
    logic        best_valid;
    logic [5:0]  best_slot;
    logic [6:0]  depth;
  } sched_result_t;

  class sched_scoreboard;
    logic                 present [64];
    aprs_pkg::ent_state_t state   [64];
    logic [2:0]           prio    [64];
    logic [31:0]          queued  [64];
    logic [31:0]          start   [64];
    logic [31:0]          cwait   [64];
    logic [31:0]          twait   [64];
    logic [31:0]          ccalls  [64];
    logic [31:0]          tcalls  [64];
    sched_result_t pending[$];
    int mismatches;
    int checked;

    function void clear_slot(int s);
      present[s] = 0; state[s] = aprs_pkg::ST_IDLE; prio[s] = aprs_pkg::PRIO_NORMAL;
      queued[s] = 0; start[s] = 0; cwait[s] = 0; twait[s] = 0;
      ccalls[s] = 0; tcalls[s] = 0;
    endfunction

    function new();
      for (int s = 0; s < 64; s++) clear_slot(s);
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {1'b0, b};
      return (t >= 33'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
    endfunction

    function void note_event(aprs_pkg::mode_t m, int s, logic [2:0] np, logic [31:0] now);
      sched_result_t r;
      int best;
      int depth;
      bit found;
      best = 0; depth = 0; found = 0;
      if (m <= aprs_pkg::MODE_IDLE && !present[s]) begin
        clear_slot(s);
        present[s] = 1;
      end
      case (m)
        aprs_pkg::MODE_SET_PRIO: prio[s] = (np > aprs_pkg::PRIO_MAX) ? aprs_pkg::PRIO_MAX : np;
        aprs_pkg::MODE_READY: begin
          if (state[s] == aprs_pkg::ST_WTOOL && start[s] != 0)
            twait[s] = sat_sum(twait[s], now - start[s]);
          state[s] = aprs_pkg::ST_READY;
          queued[s] = now;
        end
        aprs_pkg::MODE_WCOMP: begin
          state[s] = aprs_pkg::ST_WCOMP;
          start[s] = now;
          ccalls[s] = sat_sum(ccalls[s], 32'd1);
        end
        aprs_pkg::MODE_WTOOL: begin
          if (state[s] == aprs_pkg::ST_WCOMP && start[s] != 0)
            cwait[s] = sat_sum(cwait[s], now - start[s]);
          state[s] = aprs_pkg::ST_WTOOL;
          start[s] = now;
          tcalls[s] = sat_sum(tcalls[s], 32'd1);
        end
        aprs_pkg::MODE_DONE: begin
          if (start[s] != 0) begin
            if (state[s] == aprs_pkg::ST_WCOMP)
              cwait[s] = sat_sum(cwait[s], now - start[s]);
            else if (state[s] == aprs_pkg::ST_WTOOL)
              twait[s] = sat_sum(twait[s], now - start[s]);
          end
          state[s] = aprs_pkg::ST_DONE;
        end
        aprs_pkg::MODE_IDLE: state[s] = aprs_pkg::ST_IDLE;
        aprs_pkg::MODE_REMOVE: clear_slot(s);
        default: ;
      endcase
      for (int i = 0; i < 64; i++) begin
        if (present[i]) begin
          if (state[i] == aprs_pkg::ST_READY || state[i] == aprs_pkg::ST_WCOMP) depth++;
          if (state[i] == aprs_pkg::ST_READY && (!found || prio[i] < prio[best] ||
              (prio[i] == prio[best] && queued[i] < queued[best]))) begin
            best = i;
            found = 1;
          end
        end
      end
      r = '0;
      r.present = present[s];
      r.state = present[s] ? state[s] : aprs_pkg::ST_IDLE;
      r.prio = present[s] ? prio[s] : aprs_pkg::PRIO_NORMAL;
      if (present[s]) begin
        r.ccalls = ccalls[s]; r.tcalls = tcalls[s];
        r.cwait = cwait[s]; r.twait = twait[s];
      end
      r.best_valid = found;
      r.best_slot = found ? best[5:0] : 6'd0;
      r.depth = depth[6:0];
      pending = {pending, r};
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %0d: expected %p, got %p", checked, want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_mode = 0;
  logic [5:0] in_agent_slot = 0;
  logic [2:0] in_new_priority = 0;
  logic [31:0] in_now_time = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_slot_present;
  logic [2:0] out_slot_state;
  logic [2:0] out_slot_priority;
  logic [31:0] out_compute_calls;
  logic [31:0] out_tool_calls_count;
  logic [31:0] out_compute_wait_total;
  logic [31:0] out_tool_wait_total;
  logic out_best_valid;
  logic [5:0] out_best_slot;
  logic [6:0] out_compute_queue_depth;

  sched_scoreboard sb;
  bit quiet_phase = 0;
  bit hold_request = 0;
  int events_sent = 0;
  logic [31:0] clock_ms = 32'd1;

  agent_priority_ready_scheduler_top DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_slot_present, out_slot_state, out_slot_priority,
                       out_compute_calls, out_tool_calls_count, out_compute_wait_total,
                       out_tool_wait_total, out_best_valid, out_best_slot,
                       out_compute_queue_depth});
  end

  initial begin : receiver
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1;
        hold = 0;
        while (hold < 2000) begin
          @(posedge clk);
          hold++;
        end
        hold_request = 0;
        out_stall <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_event(aprs_pkg::mode_t m, logic [5:0] s, logic [2:0] np,
                            logic [31:0] now);
    in_valid <= 1;
    in_mode <= m;
    in_agent_slot <= s;
    in_new_priority <= np;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(m, s, np, now);
    events_sent++;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [31:0] now;
    logic [5:0] s;
    int pick;
    pick = $urandom_range(0, 19);
    s = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 11));
    if (pick == 0) now = $urandom;
    else if (pick == 1) now = 0;
    else begin
      clock_ms = clock_ms + $urandom_range(0, 300);
      now = clock_ms;
    end
    send_event(aprs_pkg::mode_t'($urandom_range(0, 7)), s, 3'($urandom), now);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_event(aprs_pkg::MODE_QUERY, 6'd0, 3'd0, 32'd0);
    send_event(aprs_pkg::MODE_SET_PRIO, 6'd63, 3'd7, 32'd5);
    send_event(aprs_pkg::MODE_SET_PRIO, 6'd1, 3'd0, 32'd5);
    send_event(aprs_pkg::MODE_READY, 6'd63, 3'd0, 32'd10);
    send_event(aprs_pkg::MODE_READY, 6'd1, 3'd0, 32'd20);
    send_event(aprs_pkg::MODE_READY, 6'd2, 3'd0, 32'd20);
    send_event(aprs_pkg::MODE_SET_PRIO, 6'd2, 3'd0, 32'd20);
    send_event(aprs_pkg::MODE_READY, 6'd3, 3'd0, 32'd15);
    send_event(aprs_pkg::MODE_SET_PRIO, 6'd3, 3'd0, 32'd15);
    send_event(aprs_pkg::MODE_WCOMP, 6'd4, 3'd0, 32'hFFFF_FFF0);
    send_event(aprs_pkg::MODE_WTOOL, 6'd4, 3'd0, 32'd16);
    send_event(aprs_pkg::MODE_READY, 6'd4, 3'd0, 32'd0);
    send_event(aprs_pkg::MODE_WCOMP, 6'd5, 3'd0, 32'd0);
    send_event(aprs_pkg::MODE_DONE, 6'd5, 3'd0, 32'd50);
    send_event(aprs_pkg::MODE_WCOMP, 6'd6, 3'd0, 32'd1);
    send_event(aprs_pkg::MODE_WTOOL, 6'd6, 3'd0, 32'hFFFF_FFFF);
    send_event(aprs_pkg::MODE_DONE, 6'd6, 3'd0, 32'd0);
    send_event(aprs_pkg::MODE_WTOOL, 6'd7, 3'd0, 32'd100);
    send_event(aprs_pkg::MODE_DONE, 6'd7, 3'd0, 32'd40);
    send_event(aprs_pkg::MODE_IDLE, 6'd3, 3'd0, 32'd60);
    send_event(aprs_pkg::MODE_REMOVE, 6'd1, 3'd0, 32'd60);
    send_event(aprs_pkg::MODE_REMOVE, 6'd40, 3'd0, 32'd60);
    send_event(aprs_pkg::MODE_QUERY, 6'd1, 3'd0, 32'd60);
    drain();
    hold_request = 1;
    for (int i = 0; i < 20; i++) send_random();
    drain();
    for (int i = 0; i < 1300; i++) send_random();
    drain();
    quiet_phase = 1;
    for (int i = 0; i < 130; i++) send_random();
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d scheduling events over all modes and %0d result beats checked.",
             events_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/aprs_pkg.sv
rtl/core/aprs_ram.sv
rtl/core/agent_priority_ready_scheduler_top.sv
sim/tb_agent_priority_ready_scheduler_top.sv
